// ===== src/touch_hit_region_finder_macros.svh =====
// Assertion macros for the checker file of the hit region finder.
// Depends on nothing; the including module supplies clock and reset.
`ifndef TOUCH_HIT_REGION_FINDER_MACROS_SVH
`define TOUCH_HIT_REGION_FINDER_MACROS_SVH

// Checked only while out of reset.
`define THRF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define THRF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== src/thrf_pkg.sv =====
// Types and constants for the touch hit region finder.
// Used by thrf_cell, touch_hit_region_finder and thrf_checker; depends on nothing.
package thrf_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] KIND_RECT   = 2'd0;
   localparam logic [1:0] KIND_CIRCLE = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // region payload: a = top/center x, b = bottom/center y, c = left/radius, d = right
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] d;
   } thrf_vals_type;

   // scan token walking down the cell chain
   typedef struct packed {
      logic       valid;
      logic       done;
      logic       found;
      logic [3:0] index;
      logic [7:0] px;
      logic [7:0] py;
   } thrf_token_type;

endpackage

// ===== src/touch_hit_region_finder.sv =====
// Top level of the touch hit region finder: a chain of region cells plus
// the request and response control. Depends on thrf_pkg and thrf_cell.
//
//   channel | direction | tdata                          | tuser
//   req_    | in        | index, region values, point    | cmd, entry_kind
//   rsp_    | out       | hit_found, hit_index           | -
//
// Every item, write or query, produces a response once its scan token has
// passed every cell register. One item is in the chain at a time, so a new
// item is accepted only after the last has left it; a response register plus
// a one-entry hold slot let the next item enter while a response still waits.
// req_tready is low in reset, while an item is in the chain or while hold is full.
// Reset turns every table slot into an end marker at once.
module touch_hit_region_finder
   import thrf_pkg::*;
#(
   parameter int MAX_REGIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] entry_index, [11:4] top_or_center_x, [19:12] bottom_or_center_y,
   // [27:20] left_or_radius, [35:28] right_edge, [43:36] point_x,
   // [51:44] point_y, [52] touch_valid, [55:53] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd, [2:1] entry_kind
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] hit_found, [4:1] hit_index, [7:5] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   thrf_token_type tok [MAX_REGIONS+1];

   logic          accept, wr_en, rsp_take, exit_v;
   logic [4:0]    exit_data;
   thrf_vals_type wr_vals;

   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_data_ff, rsp_data_in;
   logic       hold_valid_ff, hold_valid_in;
   logic [4:0] hold_data_ff, hold_data_in;

   assign req_tready = !reset && !busy_ff && !hold_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (req_tuser[0] == CMD_WRITE);

   assign wr_vals.a = req_tdata[11:4];
   assign wr_vals.b = req_tdata[19:12];
   assign wr_vals.c = req_tdata[27:20];
   assign wr_vals.d = req_tdata[35:28];

   always_comb begin
      tok[0].valid = accept;
      tok[0].done  = (req_tuser[0] == CMD_WRITE) || !req_tdata[52];
      tok[0].found = 1'b0;
      tok[0].index = 4'd0;
      tok[0].px    = req_tdata[43:36];
      tok[0].py    = req_tdata[51:44];
   end

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      thrf_cell #(.INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en),
         .wr_index (req_tdata[3:0]),
         .wr_kind  (req_tuser[2:1]),
         .wr_vals  (wr_vals),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   assign exit_v    = tok[MAX_REGIONS].valid;
   assign exit_data = {tok[MAX_REGIONS].index, tok[MAX_REGIONS].found};
   assign rsp_take  = rsp_valid_ff && rsp_tready;

   always_comb begin
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (exit_v) begin
         busy_in = 1'b0;
      end
      if (!rsp_valid_ff || rsp_take) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = hold_data_ff;
            hold_valid_in = 1'b0;
         end else if (exit_v) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = exit_data;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (exit_v) begin
         hold_valid_in = 1'b1;
         hold_data_in  = exit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

// ===== src/thrf_cell.sv =====
// One table slot of the hit region finder: holds its region and tests the
// passing scan token against it. Depends on thrf_pkg.
module thrf_cell
   import thrf_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [3:0]     wr_index,
   input  logic [1:0]     wr_kind,
   input  thrf_vals_type  wr_vals,
   input  thrf_token_type tok_in,
   output thrf_token_type tok_out
);

   localparam logic [3:0] INDEX_LO = 4'(INDEX);

   logic [1:0]     kind_ff;
   thrf_vals_type  vals_ff;
   thrf_token_type tok_ff, tok_next_in;

   logic       sel;
   logic [8:0] dxl, dwx, dyt, dhy;
   logic       rect_hit;
   logic [8:0] cdx, cdy;
   logic [7:0] mx, my;
   logic [15:0] sqx, sqy, rsq;
   logic [16:0] dsq;
   logic       circ_hit, hit;

   assign sel = wr_en && (int'(wr_index) == INDEX);

   always_comb begin
      dxl = {1'b0, tok_in.px} - {1'b0, vals_ff.c};
      dwx = {1'b0, vals_ff.d} - {1'b0, vals_ff.c};
      dyt = {1'b0, tok_in.py} - {1'b0, vals_ff.a};
      dhy = {1'b0, vals_ff.b} - {1'b0, vals_ff.a};
      // wrapped 9-bit differences compare as unsigned values
      rect_hit = (dxl < dwx) && (dyt < dhy);

      cdx = {1'b0, vals_ff.a} - {1'b0, tok_in.px};
      cdy = {1'b0, vals_ff.b} - {1'b0, tok_in.py};
      mx = cdx[8] ? 8'(-cdx) : cdx[7:0];
      my = cdy[8] ? 8'(-cdy) : cdy[7:0];
      sqx = 16'(mx) * 16'(mx);
      sqy = 16'(my) * 16'(my);
      rsq = 16'(vals_ff.c) * 16'(vals_ff.c);
      dsq = {1'b0, sqx} + {1'b0, sqy};
      circ_hit = dsq < {1'b0, rsq};

      hit = (kind_ff == KIND_CIRCLE) ? circ_hit : rect_hit;
   end

   always_comb begin
      tok_next_in = tok_in;
      if (!tok_in.done) begin
         if (kind_ff == KIND_END) begin
            tok_next_in.done = 1'b1;
         end else if (hit) begin
            tok_next_in.done  = 1'b1;
            tok_next_in.found = 1'b1;
            tok_next_in.index = INDEX_LO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_END;
         tok_ff.valid <= 1'b0;
      end else begin
         if (sel) begin
            kind_ff <= wr_kind;
         end
         tok_ff.valid <= tok_next_in.valid;
      end
      if (sel) begin
         vals_ff <= wr_vals;
      end
      tok_ff.done  <= tok_next_in.done;
      tok_ff.found <= tok_next_in.found;
      tok_ff.index <= tok_next_in.index;
      tok_ff.px    <= tok_next_in.px;
      tok_ff.py    <= tok_next_in.py;
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/thrf_checker.sv =====
// Port-level checks for the touch hit region finder, bound to the top level.
// Depends on thrf_pkg and touch_hit_region_finder_macros.svh.
`include "touch_hit_region_finder_macros.svh"

module thrf_checker
   import thrf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `THRF_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "item dropped")
   `THRF_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "item changed")
   `THRF_ASSERT(a_miss_index, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[4:1] == '0, "bad index")
   `THRF_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_tvalid, "valid after reset")

endmodule

bind touch_hit_region_finder thrf_checker u_thrf_checker (.*);
